>>> hdl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

    // Fixed field widths
    localparam int KEY_W = 8;
    localparam int CAP_W = 5;

    // Capacity register value after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Operation codes carried by the kind field
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic enq;  // accepted enqueue that fits
        logic deq;  // accepted dequeue of a held entry
    } t_cell_ctrl;

endpackage

>>> hdl/spq_cell.sv
// One slot of the shift-register priority queue: holds one entry and trades with neighbors.
module spq_cell #(
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  spq_pkg::t_cell_ctrl       i_ctrl,
    input  logic [spq_pkg::KEY_W-1:0] i_new_key,
    input  logic [PAYLOAD_BITS-1:0]   i_new_payload,
    // left neighbor (toward the head)
    input  logic                      i_left_occ,
    input  logic                      i_left_ins,
    input  logic [spq_pkg::KEY_W-1:0] i_left_key,
    input  logic [PAYLOAD_BITS-1:0]   i_left_payload,
    // right neighbor (toward the tail)
    input  logic                      i_right_occ,
    input  logic [spq_pkg::KEY_W-1:0] i_right_key,
    input  logic [PAYLOAD_BITS-1:0]   i_right_payload,
    // this cell's state
    output logic                      o_occ,
    output logic                      o_ins,
    output logic [spq_pkg::KEY_W-1:0] o_key,
    output logic [PAYLOAD_BITS-1:0]   o_payload
);

    logic                      r_occ;
    logic                      n_occ;
    logic [spq_pkg::KEY_W-1:0] r_key;
    logic [spq_pkg::KEY_W-1:0] n_key;
    logic [PAYLOAD_BITS-1:0]   r_payload;
    logic [PAYLOAD_BITS-1:0]   n_payload;
    logic                      ins;

    // New entry goes at or before this slot: slot is empty or holds a greater key
    assign ins = !r_occ || (r_key > i_new_key);

    // Next state: insert/shift right on enqueue, shift left on dequeue
    always_comb begin
        n_occ     = r_occ;
        n_key     = r_key;
        n_payload = r_payload;
        if (i_ctrl.enq) begin
            n_occ = r_occ | i_left_occ;
            if (ins) begin
                if (i_left_ins) begin
                    n_key     = i_left_key;
                    n_payload = i_left_payload;
                end else begin
                    n_key     = i_new_key;
                    n_payload = i_new_payload;
                end
            end
        end else if (i_ctrl.deq) begin
            n_occ     = i_right_occ;
            n_key     = i_right_key;
            n_payload = i_right_payload;
        end
    end

    // Occupancy is control state; entry data needs no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_payload <= n_payload;
    end

    assign o_occ     = r_occ;
    assign o_ins     = ins;
    assign o_key     = r_key;
    assign o_payload = r_payload;

endmodule

>>> hdl/sorted_priority_queue.sv
// Top level of the sorted priority queue: command decode, cell chain and result register.
//
// Usage:
//   Command channel (i_cmd_valid / o_cmd_stall) carries one item: i_kind selects
//   enqueue (i_key, i_payload) or dequeue. Result channel (o_res_valid / i_res_stall)
//   returns one item per command: the dequeued entry (o_out_valid, o_out_key,
//   o_out_payload, zero otherwise), o_error for an enqueue into a full queue or a
//   dequeue from an empty one, and the status after the command (o_is_empty,
//   o_is_full, o_entry_count).
//   Entries sit in a row of DEPTH cells kept in key order, head in cell 0. Every
//   cell compares its key with the incoming one and all cells shift in the same
//   cycle, so the time a command takes does not depend on the fill level.
//   The result is registered and appears in the cycle after the command is accepted.
//   Throughput: one command per cycle while o_cmd_stall is low, set by the
//   compare-and-shift of the chain and the one result register.
//   Stall: while a result waits under i_res_stall, o_cmd_stall is high and the
//   queue holds its contents; a result taken in the same cycle frees the slot.
//   Reset: queue empty, capacity 16 (saturated to DEPTH), no result pending. The user
//   writes capacity (i_cfg_we / i_cfg_wdata) only while idle, not enforced; entries kept.
module sorted_priority_queue #(
    parameter int DEPTH        = 16,
    parameter int PAYLOAD_BITS = 32,
    localparam int CNT_W       = $clog2(DEPTH + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // command channel
    input  logic                      i_cmd_valid,
    output logic                      o_cmd_stall,
    input  logic                      i_kind,
    input  logic [spq_pkg::KEY_W-1:0] i_key,
    input  logic [PAYLOAD_BITS-1:0]   i_payload,
    // result channel
    output logic                      o_res_valid,
    input  logic                      i_res_stall,
    output logic                      o_out_valid,
    output logic [spq_pkg::KEY_W-1:0] o_out_key,
    output logic [PAYLOAD_BITS-1:0]   o_out_payload,
    output logic                      o_error,
    output logic                      o_is_empty,
    output logic                      o_is_full,
    output logic [CNT_W-1:0]          o_entry_count,
    // capacity register
    input  logic                      i_cfg_we,
    input  logic [spq_pkg::CAP_W-1:0] i_cfg_wdata
);

    localparam int CMP_W = (CNT_W > spq_pkg::CAP_W) ? CNT_W : spq_pkg::CAP_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

    logic [spq_pkg::CAP_W-1:0] r_cap;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;

    logic                      r_res_valid;
    logic                      r_out_valid;
    logic [spq_pkg::KEY_W-1:0] r_out_key;
    logic [PAYLOAD_BITS-1:0]   r_out_payload;
    logic                      r_error;
    logic                      r_is_empty;
    logic                      r_is_full;

    logic [CMP_W-1:0]          eff_cap;
    logic                      full_now;
    logic                      full_next;
    logic                      cmd_accept;
    logic                      enq_ok;
    logic                      deq_ok;
    spq_pkg::t_cell_ctrl       ctrl;

    logic [DEPTH-1:0]          occ;
    logic [DEPTH-1:0]          ins;
    logic [spq_pkg::KEY_W-1:0] cell_key [DEPTH];
    logic [PAYLOAD_BITS-1:0]   cell_pay [DEPTH];

    // Capacity saturates at the built depth
    always_comb begin
        if (CMP_W'(r_cap) > DEPTH_C) begin
            eff_cap = DEPTH_C;
        end else begin
            eff_cap = CMP_W'(r_cap);
        end
    end

    // Command decode
    assign o_cmd_stall = r_res_valid && i_res_stall;
    assign cmd_accept  = i_cmd_valid && !o_cmd_stall;
    assign full_now    = CMP_W'(r_count) >= eff_cap;
    assign enq_ok      = cmd_accept && (i_kind == spq_pkg::KIND_ENQ) && !full_now;
    assign deq_ok      = cmd_accept && (i_kind == spq_pkg::KIND_DEQ) && (r_count != '0);
    assign ctrl.enq    = enq_ok;
    assign ctrl.deq    = deq_ok;

    // Count update
    always_comb begin
        n_count = r_count;
        if (enq_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (deq_ok) begin
            n_count = r_count - CNT_W'(1);
        end
    end
    assign full_next = CMP_W'(n_count) >= eff_cap;

    // Chain of cells, head at index 0
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic                      left_occ;
            logic                      left_ins;
            logic [spq_pkg::KEY_W-1:0] left_key;
            logic [PAYLOAD_BITS-1:0]   left_pay;
            logic                      right_occ;
            logic [spq_pkg::KEY_W-1:0] right_key;
            logic [PAYLOAD_BITS-1:0]   right_pay;

            if (gi == 0) begin : g_head
                assign left_occ = 1'b1;
                assign left_ins = 1'b0;
                assign left_key = cell_key[gi];
                assign left_pay = cell_pay[gi];
            end else begin : g_mid
                assign left_occ = occ[gi-1];
                assign left_ins = ins[gi-1];
                assign left_key = cell_key[gi-1];
                assign left_pay = cell_pay[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                assign right_occ = 1'b0;
                assign right_key = cell_key[gi];
                assign right_pay = cell_pay[gi];
            end else begin : g_body
                assign right_occ = occ[gi+1];
                assign right_key = cell_key[gi+1];
                assign right_pay = cell_pay[gi+1];
            end

            spq_cell #(
                .PAYLOAD_BITS(PAYLOAD_BITS)
            ) u_cell (
                .i_clk          (i_clk),
                .i_rst_n        (i_rst_n),
                .i_ctrl         (ctrl),
                .i_new_key      (i_key),
                .i_new_payload  (i_payload),
                .i_left_occ     (left_occ),
                .i_left_ins     (left_ins),
                .i_left_key     (left_key),
                .i_left_payload (left_pay),
                .i_right_occ    (right_occ),
                .i_right_key    (right_key),
                .i_right_payload(right_pay),
                .o_occ          (occ[gi]),
                .o_ins          (ins[gi]),
                .o_key          (cell_key[gi]),
                .o_payload      (cell_pay[gi])
            );
        end
    endgenerate

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= spq_pkg::CAP_RESET;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_count <= n_count;
            if (cmd_accept) begin
                r_res_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // Result register, loaded with each accepted item
    always_ff @(posedge i_clk) begin
        if (cmd_accept) begin
            r_out_valid   <= deq_ok;
            r_out_key     <= deq_ok ? cell_key[0] : '0;
            r_out_payload <= deq_ok ? cell_pay[0] : '0;
            r_error       <= !(enq_ok || deq_ok);
            r_is_empty    <= (n_count == '0);
            r_is_full     <= full_next;
        end
    end

    assign o_res_valid   = r_res_valid;
    assign o_out_valid   = r_out_valid;
    assign o_out_key     = r_out_key;
    assign o_out_payload = r_out_payload;
    assign o_error       = r_error;
    assign o_is_empty    = r_is_empty;
    assign o_is_full     = r_is_full;
    assign o_entry_count = r_count;

    // Occupied cells form a prefix of the chain whose length is the count
    a_occ_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CNT_W'($countones(occ)) == r_count) && (occ[0] || (r_count == '0)))
        else $error("cell occupancy disagrees with entry count");

    // Count never exceeds the built depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= DEPTH_C)
        else $error("entry count beyond depth");

    // A successful dequeue returns an entry in the next result
    a_deq_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        deq_ok |=> (o_res_valid && o_out_valid && !o_error))
        else $error("dequeue did not return an entry");

    // A successful enqueue grows the queue by exactly one
    a_enq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        enq_ok |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("enqueue did not grow the count");

    // Head key never exceeds its neighbor's while both are held
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (occ[0] && occ[1]) |-> (cell_key[0] <= cell_key[1]))
        else $error("head entry out of key order");

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for sorted_priority_queue: directed cases, then random traffic.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    localparam int PAY_W = 32;
    localparam int CNT_W = 5;

    // Receiver stall patterns
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    // One result item as the queue should answer it
    typedef struct {
        logic                      got_entry;
        logic [spq_pkg::KEY_W-1:0] key;
        logic [PAY_W-1:0]          payload;
        logic                      error;
        logic                      empty;
        logic                      full;
        logic [CNT_W-1:0]          count;
    } t_pq_reply;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cmd_valid = 1'b0;
    logic                      o_cmd_stall;
    logic                      i_kind = spq_pkg::KIND_ENQ;
    logic [spq_pkg::KEY_W-1:0] i_key = '0;
    logic [PAY_W-1:0]          i_payload = '0;
    logic                      o_res_valid;
    logic                      i_res_stall = 1'b0;
    logic                      o_out_valid;
    logic [spq_pkg::KEY_W-1:0] o_out_key;
    logic [PAY_W-1:0]          o_out_payload;
    logic                      o_error;
    logic                      o_is_empty;
    logic                      o_is_full;
    logic [CNT_W-1:0]          o_entry_count;
    logic                      i_cfg_we = 1'b0;
    logic [spq_pkg::CAP_W-1:0] i_cfg_wdata = '0;

    // Predicted queue contents, kept as a circular store
    logic [spq_pkg::KEY_W-1:0] slot_key [DEPTH];
    logic [PAY_W-1:0]          slot_pay [DEPTH];
    int                        head_idx = 0;
    int                        held_cnt = 0;
    logic [spq_pkg::CAP_W-1:0] cap_reg = spq_pkg::CAP_RESET;

    t_pq_reply   awaited_replies [$];
    int          fail_count = 0;
    t_stall_mode stall_mode = STALL_NONE;
    logic [5:0]  stall_age = '0;

    sorted_priority_queue #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAY_W)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (i_cmd_valid),
        .o_cmd_stall   (o_cmd_stall),
        .i_kind        (i_kind),
        .i_key         (i_key),
        .i_payload     (i_payload),
        .o_res_valid   (o_res_valid),
        .i_res_stall   (i_res_stall),
        .o_out_valid   (o_out_valid),
        .o_out_key     (o_out_key),
        .o_out_payload (o_out_payload),
        .o_error       (o_error),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full),
        .o_entry_count (o_entry_count),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one operation to the predicted queue and return its answer
    function automatic t_pq_reply pq_apply_op(input logic kind,
                                              input logic [spq_pkg::KEY_W-1:0] key,
                                              input logic [PAY_W-1:0] pay);
        t_pq_reply r;
        int        pos;
        int        lim;
        lim = (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
        r = '{default: '0};
        if (kind == spq_pkg::KIND_ENQ) begin
            if (held_cnt >= lim) begin
                r.error = 1'b1;
            end else begin
                // insert after every entry whose key is not greater
                pos = 0;
                while (pos < held_cnt && slot_key[(head_idx + pos) % DEPTH] <= key)
                    pos++;
                for (int j = held_cnt; j > pos; j--) begin
                    slot_key[(head_idx + j) % DEPTH] = slot_key[(head_idx + j - 1) % DEPTH];
                    slot_pay[(head_idx + j) % DEPTH] = slot_pay[(head_idx + j - 1) % DEPTH];
                end
                slot_key[(head_idx + pos) % DEPTH] = key;
                slot_pay[(head_idx + pos) % DEPTH] = pay;
                held_cnt++;
            end
        end else begin
            if (held_cnt == 0) begin
                r.error = 1'b1;
            end else begin
                r.got_entry = 1'b1;
                r.key       = slot_key[head_idx];
                r.payload   = slot_pay[head_idx];
                held_cnt--;
                head_idx = (held_cnt == 0) ? 0 : (head_idx + 1) % DEPTH;
            end
        end
        r.empty = (held_cnt == 0);
        r.full  = (held_cnt >= lim);
        r.count = held_cnt[CNT_W-1:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [PAY_W-1:0] want,
                                        input logic [PAY_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Present one item and hold it until accepted; valid is left high
    task automatic push_command(input logic kind, input logic [spq_pkg::KEY_W-1:0] key,
                                input logic [PAY_W-1:0] pay);
        i_cmd_valid <= 1'b1;
        i_kind      <= kind;
        i_key       <= key;
        i_payload   <= pay;
        do
            @(posedge i_clk);
        while (o_cmd_stall !== 1'b0);
        awaited_replies.push_back(pq_apply_op(kind, key, pay));
    endtask

    task automatic idle_cycles(input int n);
        i_cmd_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Stop sending until every answer is back, then let the pipeline settle
    task automatic wait_drained();
        i_cmd_valid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [spq_pkg::CAP_W-1:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        cap_reg = value;
        i_cfg_we <= 1'b0;
    endtask

    // Empty refusal, key extremes and arrival order among equal keys
    task automatic test_empty_and_order();
        push_command(spq_pkg::KIND_DEQ, 8'h00, 32'h0);
        push_command(spq_pkg::KIND_ENQ, 8'hff, 32'hffff_ffff);
        push_command(spq_pkg::KIND_ENQ, 8'h00, 32'h0000_0000);
        push_command(spq_pkg::KIND_ENQ, 8'h08, 32'h0000_0001);
        push_command(spq_pkg::KIND_ENQ, 8'h08, 32'h0000_0002);
        push_command(spq_pkg::KIND_ENQ, 8'h08, 32'h0000_0003);
        repeat (6) push_command(spq_pkg::KIND_DEQ, 8'hff, 32'hffff_ffff);
    endtask

    // Full refusal at a small capacity
    task automatic test_small_capacity();
        write_capacity(5'd2);
        push_command(spq_pkg::KIND_ENQ, 8'h05, 32'h1111_1111);
        push_command(spq_pkg::KIND_ENQ, 8'h05, 32'h2222_2222);
        push_command(spq_pkg::KIND_ENQ, 8'h01, 32'h3333_3333);
        push_command(spq_pkg::KIND_DEQ, 8'h00, 32'h0);
        push_command(spq_pkg::KIND_DEQ, 8'h00, 32'h0);
    endtask

    // Capacity zero: always full, every enqueue refused
    task automatic test_zero_capacity();
        write_capacity(5'd0);
        push_command(spq_pkg::KIND_ENQ, 8'h10, 32'hdead_beef);
        push_command(spq_pkg::KIND_DEQ, 8'h00, 32'h0);
    endtask

    // Capacity lowered below the held count: entries kept, dequeues still work
    task automatic test_capacity_shrink();
        write_capacity(5'd16);
        push_command(spq_pkg::KIND_ENQ, 8'h30, 32'ha5a5_a5a5);
        push_command(spq_pkg::KIND_ENQ, 8'h10, 32'h5a5a_5a5a);
        push_command(spq_pkg::KIND_ENQ, 8'h20, 32'h0f0f_0f0f);
        write_capacity(5'd1);
        push_command(spq_pkg::KIND_ENQ, 8'h00, 32'h1234_5678);
        repeat (3) push_command(spq_pkg::KIND_DEQ, 8'h00, 32'h0);
    endtask

    // Random traffic over a sweep of capacities and dequeue biases
    task automatic test_random_traffic();
        logic [spq_pkg::CAP_W-1:0] caps [10] = '{5'd16, 5'd31, 5'd1, 5'd17, 5'd0,
                                                 5'd8, 5'd2, 5'd16, 5'd16, 5'd16};
        int                        deq_pct;
        int                        burst_left;
        int                        pick;
        logic                      kind;
        logic [spq_pkg::KEY_W-1:0] key;
        burst_left = 0;
        for (int ph = 0; ph < 10; ph++) begin
            write_capacity(ph >= 8 ? spq_pkg::CAP_W'($urandom_range(0, 31)) : caps[ph]);
            deq_pct = (ph % 3 == 0) ? 50 : (ph % 3 == 1) ? 30 : 70;
            for (int n = 0; n < 115; n++) begin
                // one pause in the middle until everything is answered
                if (ph == 5 && n == 57)
                    wait_drained();
                if (burst_left == 0) begin
                    if (ph != 3 && ph != 7)
                        idle_cycles($urandom_range(1, 5));
                    burst_left = $urandom_range(1, 24);
                end
                burst_left--;
                kind = ($urandom_range(0, 99) < deq_pct) ? spq_pkg::KIND_DEQ
                                                         : spq_pkg::KIND_ENQ;
                // narrow keys make plenty of ties
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    key = spq_pkg::KEY_W'($urandom_range(0, 7));
                else if (pick < 60)
                    key = $urandom_range(0, 1) ? 8'hff : 8'h00;
                else
                    key = spq_pkg::KEY_W'($urandom_range(0, 255));
                push_command(kind, key, PAY_W'($urandom));
            end
        end
    endtask

    // Receiver stall, pattern changes each time the 6-bit stall_age counter wraps
    always @(posedge i_clk) begin
        stall_age <= stall_age + 1'b1;
        if (stall_age == '0)
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
        case (stall_mode)
            STALL_NONE:  i_res_stall <= 1'b0;
            STALL_LIGHT: i_res_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_res_stall <= ($urandom_range(0, 9) < 7);
            default:     i_res_stall <= stall_age[2];
        endcase
    end

    // Compare each accepted result item with the oldest prediction
    always @(posedge i_clk) begin
        t_pq_reply want;
        if (i_rst_n && o_res_valid === 1'b1 && i_res_stall == 1'b0) begin
            if (awaited_replies.size() == 0) begin
                $error("result item with no prediction waiting");
                fail_count++;
            end else begin
                want = awaited_replies.pop_front();
                check_field("out_valid", want.got_entry, o_out_valid);
                check_field("out_key", want.key, o_out_key);
                check_field("out_payload", want.payload, o_out_payload);
                check_field("error", want.error, o_error);
                check_field("is_empty", want.empty, o_is_empty);
                check_field("is_full", want.full, o_is_full);
                check_field("entry_count", want.count, o_entry_count);
            end
        end
    end

    // Hard stop
    initial begin
        #2_000_000;
        $display("tb_top: errors");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_and_order();
        test_small_capacity();
        test_zero_capacity();
        test_capacity_shrink();
        test_random_traffic();
        wait_drained();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && awaited_replies.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
